[hw/rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked assertion forms shared by the RTL that checks itself.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clk edge, off while arst_n is low
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// implication checked on every rising clk edge, off while arst_n is low
`define ASSERT_IMPL(label, ante, cons, msg) \
	`ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

[hw/rtl/lapd_pkg.sv]
// ---------------------------------------------------------------------------
// LAPD TEI management package
// Types, codes and helpers shared by the TEI management block.
// ---------------------------------------------------------------------------
package lapd_pkg;

	localparam int TIMER_W = 16;

	// event codes
	localparam logic [1:0] FN_FRAME  = 2'd0;
	localparam logic [1:0] FN_ASSIGN = 2'd1;
	localparam logic [1:0] FN_ERROR  = 2'd2;
	localparam logic [1:0] FN_TICK   = 2'd3;

	// configuration register indexes
	localparam logic [2:0] CFG_NET_SIDE     = 3'd0;
	localparam logic [2:0] CFG_FIXED_TEI    = 3'd1;
	localparam logic [2:0] CFG_TEI_ASSIGNED = 3'd2;
	localparam logic [2:0] CFG_OWN_TEI      = 3'd3;
	localparam logic [2:0] CFG_T202_TICKS   = 3'd4;

	localparam logic [15:0] T202_RESET = 16'd2000;

	// frame constants
	localparam logic [7:0] UI_CTRL   = 8'h03;
	localparam logic [7:0] CTRL_MASK = 8'hEF;
	localparam logic [7:0] ENTITY_ID = 8'h0F;
	localparam logic [7:0] MIN_LEN   = 8'd8;
	localparam logic [6:0] BCAST_TEI = 7'd127;

	// TEI message types
	localparam logic [7:0] MT_REQUEST  = 8'd1;
	localparam logic [7:0] MT_ASSIGNED = 8'd2;
	localparam logic [7:0] MT_DENIED   = 8'd3;
	localparam logic [7:0] MT_CHK_REQ  = 8'd4;
	localparam logic [7:0] MT_CHK_RES  = 8'd5;
	localparam logic [7:0] MT_REMOVE   = 8'd6;
	localparam logic [7:0] MT_VERIFY   = 8'd7;

	typedef enum logic [2:0] {
		ACT_NONE         = 3'd0,
		ACT_SEND         = 3'd1,
		ACT_ASSIGN_REQ   = 3'd2,
		ACT_ERR_RESP     = 3'd3,
		ACT_ERR_REQ      = 3'd4,
		ACT_REMOVE_REQ   = 3'd5,
		ACT_VERIFY_OTHER = 3'd6
	} action_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [7:0]  frame_len;
		logic [7:0]  ctrl_byte;
		logic [7:0]  entity_byte;
		logic [15:0] frame_ri;
		logic [7:0]  msg_type;
		logic [7:0]  ai_byte;
		logic [15:0] fresh_ri;
		logic        other_holds_tei;
		logic [15:0] other_ri;
	} item_t;

	typedef struct packed {
		logic        net_side;
		logic        fixed_tei;
		logic        tei_assigned;
		logic [6:0]  own_tei;
		logic [15:0] t202_ticks;
	} cfg_t;

	// frame check result
	typedef struct packed {
		logic       rejected;
		logic [6:0] tei;
		logic       other;
		logic       ours;
	} chk_t;

	typedef struct packed {
		logic        frame_rejected;
		action_t     action;
		logic [2:0]  tx_msg_type;
		logic [15:0] tx_ri;
		logic [7:0]  tx_ai;
		logic        tx_cr;
		logic [6:0]  assign_tei;
		logic [1:0]  fsm_state;
	} res_t;

	// T202 load value, saturated to the timer width
	function automatic logic [TIMER_W-1:0] load_ticks(input logic [15:0] t);
		logic [32:0] lim;
		logic [32:0] v;
		lim = (33'd1 << TIMER_W) - 33'd1;
		v = 33'(t);
		return TIMER_W'((v > lim) ? lim : v);
	endfunction

endpackage

[hw/rtl/lapd_frm_chk.sv]
// ---------------------------------------------------------------------------
// LAPD frame check
// Validates a received TEI management frame and extracts its TEI.
// ---------------------------------------------------------------------------
module lapd_frm_chk (
	input  lapd_pkg::item_t item,
	input  lapd_pkg::cfg_t  cfg,
	output lapd_pkg::chk_t  chk
);

	logic [6:0] tei;
	logic       mt_ok;

	assign tei = item.ai_byte[7:1];

	always_comb begin
		case (item.msg_type) inside
			lapd_pkg::MT_ASSIGNED, lapd_pkg::MT_DENIED,
			lapd_pkg::MT_CHK_REQ, lapd_pkg::MT_REMOVE: mt_ok = 1'b1;
			lapd_pkg::MT_REQUEST: mt_ok = cfg.net_side;
			default: mt_ok = 1'b0;
		endcase
	end

	always_comb begin
		chk.rejected = (cfg.fixed_tei && !cfg.net_side)
			|| (item.frame_len < lapd_pkg::MIN_LEN)
			|| ((item.ctrl_byte & lapd_pkg::CTRL_MASK) != lapd_pkg::UI_CTRL)
			|| (item.entity_byte != lapd_pkg::ENTITY_ID)
			|| !mt_ok;
		chk.tei   = tei;
		// group TEI is never held by another link
		chk.other = item.other_holds_tei && (tei != lapd_pkg::BCAST_TEI);
		chk.ours  = cfg.tei_assigned
			&& ((tei == lapd_pkg::BCAST_TEI) || (tei == cfg.own_tei));
	end

endmodule

[hw/rtl/lapd_ctl.sv]
// ---------------------------------------------------------------------------
// LAPD TEI management control
// State machine, reference number, retry count, T202 timer and result register.
// ---------------------------------------------------------------------------
module lapd_ctl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  lapd_pkg::item_t item,
	input  lapd_pkg::cfg_t  cfg,
	input  lapd_pkg::chk_t  chk,
	output lapd_pkg::res_t  res
);

	typedef enum logic [1:0] {
		ST_IDLE     = 2'd0,
		ST_IDREQ    = 2'd1,
		ST_IDVERIFY = 2'd2
	} state_t;

	state_t                       state_q, state_d;
	logic [15:0]                  own_ri_q, own_ri_d;
	logic [1:0]                   retry_q, retry_d;
	logic [lapd_pkg::TIMER_W-1:0] tcount_q, tcount_d;
	logic                         trun_q, trun_d;
	lapd_pkg::res_t               res_q, res_d;
	logic                         idle;

	function automatic lapd_pkg::res_t put_frame(input lapd_pkg::res_t r,
			input logic [7:0] mt, input logic [15:0] ri, input logic [6:0] tei,
			input logic cr);
		lapd_pkg::res_t o;
		o = r;
		o.action      = lapd_pkg::ACT_SEND;
		o.tx_msg_type = mt[2:0];
		o.tx_ri       = ri;
		o.tx_ai       = {tei, 1'b1};
		o.tx_cr       = cr;
		return o;
	endfunction

	assign idle = (state_q == ST_IDLE);

	always_comb begin
		logic [6:0] vtei;
		logic [1:0] rdec;
		vtei = cfg.tei_assigned ? cfg.own_tei : lapd_pkg::BCAST_TEI;
		rdec = retry_q - 2'd1;
		state_d  = state_q;
		own_ri_d = own_ri_q;
		retry_d  = retry_q;
		tcount_d = tcount_q;
		trun_d   = trun_q;
		res_d    = '0;
		unique case (item.func)
			lapd_pkg::FN_FRAME: begin
				if (chk.rejected) begin
					res_d.frame_rejected = 1'b1;
				end else begin
					case (item.msg_type) inside
						lapd_pkg::MT_ASSIGNED: begin
							if (idle) begin
								if (chk.other && item.frame_ri != item.other_ri)
									res_d.action = lapd_pkg::ACT_VERIFY_OTHER;
							end else if (state_q == ST_IDREQ) begin
								if (chk.other) begin
									if (item.frame_ri != item.other_ri)
										res_d.action = lapd_pkg::ACT_ERR_RESP;
								end else if (item.frame_ri == own_ri_q) begin
									trun_d = 1'b0;
									state_d = ST_IDLE;
									res_d.action = lapd_pkg::ACT_ASSIGN_REQ;
									res_d.assign_tei = chk.tei;
								end
							end
						end
						lapd_pkg::MT_REQUEST: begin
							if (idle && cfg.tei_assigned) begin
								own_ri_d = item.frame_ri;
								res_d = put_frame(res_d, lapd_pkg::MT_ASSIGNED,
									item.frame_ri, cfg.own_tei, cfg.net_side);
								state_d = ST_IDLE;
							end
						end
						lapd_pkg::MT_CHK_REQ, lapd_pkg::MT_REMOVE: begin
							if ((idle || state_q == ST_IDVERIFY) && chk.ours) begin
								trun_d = 1'b0;
								state_d = ST_IDLE;
								if (item.msg_type == lapd_pkg::MT_CHK_REQ)
									res_d = put_frame(res_d, lapd_pkg::MT_CHK_RES,
										item.fresh_ri, cfg.own_tei, cfg.net_side);
								else
									res_d.action = lapd_pkg::ACT_REMOVE_REQ;
							end
						end
						default: ; // denied: no action in any state
					endcase
				end
			end
			lapd_pkg::FN_ASSIGN: begin
				if (cfg.fixed_tei) begin
					res_d.action = lapd_pkg::ACT_ASSIGN_REQ;
					res_d.assign_tei = cfg.own_tei;
				end else if (idle && !cfg.tei_assigned) begin
					own_ri_d = item.fresh_ri;
					res_d = put_frame(res_d, lapd_pkg::MT_REQUEST, item.fresh_ri,
						lapd_pkg::BCAST_TEI, cfg.net_side);
					state_d  = ST_IDREQ;
					tcount_d = lapd_pkg::load_ticks(cfg.t202_ticks);
					trun_d   = 1'b1;
					retry_d  = 2'd3;
				end
			end
			lapd_pkg::FN_ERROR: begin
				if (!cfg.fixed_tei && idle) begin
					res_d = put_frame(res_d, lapd_pkg::MT_VERIFY, 16'd0, vtei,
						cfg.net_side);
					state_d  = ST_IDVERIFY;
					tcount_d = lapd_pkg::load_ticks(cfg.t202_ticks);
					trun_d   = 1'b1;
					retry_d  = 2'd2;
				end
			end
			lapd_pkg::FN_TICK: begin
				if (trun_q) begin
					if (tcount_q <= lapd_pkg::TIMER_W'(1)) begin
						// T202 expiry
						tcount_d = '0;
						trun_d   = 1'b0;
						if (state_q == ST_IDREQ) begin
							retry_d = rdec;
							if (rdec != 2'd0) begin
								own_ri_d = item.fresh_ri;
								res_d = put_frame(res_d, lapd_pkg::MT_REQUEST,
									item.fresh_ri, lapd_pkg::BCAST_TEI, cfg.net_side);
								tcount_d = lapd_pkg::load_ticks(cfg.t202_ticks);
								trun_d   = 1'b1;
							end else begin
								res_d.action = lapd_pkg::ACT_ERR_REQ;
								state_d = ST_IDLE;
							end
						end else if (state_q == ST_IDVERIFY) begin
							retry_d = rdec;
							if (rdec != 2'd0) begin
								res_d = put_frame(res_d, lapd_pkg::MT_VERIFY, 16'd0,
									vtei, cfg.net_side);
								tcount_d = lapd_pkg::load_ticks(cfg.t202_ticks);
								trun_d   = 1'b1;
							end else begin
								res_d.action = lapd_pkg::ACT_REMOVE_REQ;
								state_d = ST_IDLE;
							end
						end
					end else begin
						tcount_d = tcount_q - lapd_pkg::TIMER_W'(1);
					end
				end
			end
		endcase
		res_d.fsm_state = state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			own_ri_q <= '0;
			retry_q  <= '0;
			tcount_q <= '0;
			trun_q   <= 1'b0;
			res_q    <= '0;
		end else if (advance) begin
			state_q  <= state_d;
			own_ri_q <= own_ri_d;
			retry_q  <= retry_d;
			tcount_q <= tcount_d;
			trun_q   <= trun_d;
			res_q    <= res_d;
		end
	end

	assign res = res_q;

endmodule

[hw/rtl/lapd_tei_management_fsm_core.sv]
// ---------------------------------------------------------------------------
// LAPD TEI management core
// Q.921 style TEI assignment, check, removal and verify machine.
// ---------------------------------------------------------------------------
//  channel | handshake           | payload
//  in      | in_valid / in_ready | func .. other_ri, one event per item
//  out     | out_valid/out_ready | frame_rejected .. fsm_state, one per item
//  cfg     | cfg_we              | cfg_index, cfg_data
//
//  An accepted item is held in the input register; its result is then held in the
//  result register until it leaves.
//  Throughput: one item per cycle while the output is not stalled; the whole
//  decision is one combinational pass. A stalled output holds the result register
//  and the input register; in_ready falls only when both are full.
//  Reset clears state, retry count, timer and configuration (T202 to 2000).
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lapd_tei_management_fsm_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [7:0]  frame_len,
	input  logic [7:0]  ctrl_byte,
	input  logic [7:0]  entity_byte,
	input  logic [15:0] frame_ri,
	input  logic [7:0]  msg_type,
	input  logic [7:0]  ai_byte,
	input  logic [15:0] fresh_ri,
	input  logic        other_holds_tei,
	input  logic [15:0] other_ri,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        frame_rejected,
	output logic [2:0]  action,
	output logic [2:0]  tx_msg_type,
	output logic [15:0] tx_ri,
	output logic [7:0]  tx_ai,
	output logic        tx_cr,
	output logic [6:0]  assign_tei,
	output logic [1:0]  fsm_state
);

	lapd_pkg::cfg_t  cfg_q;
	lapd_pkg::item_t item_s1;
	logic            valid_s1;
	logic            out_valid_q;
	logic            advance;
	lapd_pkg::chk_t  chk;
	lapd_pkg::res_t  res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.net_side     <= 1'b0;
			cfg_q.fixed_tei    <= 1'b0;
			cfg_q.tei_assigned <= 1'b0;
			cfg_q.own_tei      <= '0;
			cfg_q.t202_ticks   <= lapd_pkg::T202_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lapd_pkg::CFG_NET_SIDE:     cfg_q.net_side     <= cfg_data[0];
				lapd_pkg::CFG_FIXED_TEI:    cfg_q.fixed_tei    <= cfg_data[0];
				lapd_pkg::CFG_TEI_ASSIGNED: cfg_q.tei_assigned <= cfg_data[0];
				lapd_pkg::CFG_OWN_TEI:      cfg_q.own_tei      <= cfg_data[6:0];
				lapd_pkg::CFG_T202_TICKS:   cfg_q.t202_ticks   <= cfg_data;
				default: ; // drop writes beyond the register list
			endcase
		end
	end

	// advance the input register into the result register when it has room
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (advance)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.func            <= func;
			item_s1.frame_len       <= frame_len;
			item_s1.ctrl_byte       <= ctrl_byte;
			item_s1.entity_byte     <= entity_byte;
			item_s1.frame_ri        <= frame_ri;
			item_s1.msg_type        <= msg_type;
			item_s1.ai_byte         <= ai_byte;
			item_s1.fresh_ri        <= fresh_ri;
			item_s1.other_holds_tei <= other_holds_tei;
			item_s1.other_ri        <= other_ri;
		end
	end

	lapd_frm_chk u_frm_chk (
		.item (item_s1),
		.cfg  (cfg_q),
		.chk  (chk)
	);

	lapd_ctl u_ctl (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg_q),
		.chk     (chk),
		.res     (res)
	);

	assign out_valid      = out_valid_q;
	assign frame_rejected = res.frame_rejected;
	assign action         = res.action;
	assign tx_msg_type    = res.tx_msg_type;
	assign tx_ri          = res.tx_ri;
	assign tx_ai          = res.tx_ai;
	assign tx_cr          = res.tx_cr;
	assign assign_tei     = res.assign_tei;
	assign fsm_state      = res.fsm_state;

	`ASSERT_CLK(a_in_lands, (in_valid && in_ready) |=> valid_s1,
		"accepted item not held in input register")
	`ASSERT_IMPL(a_frame_fields, out_valid && (action != lapd_pkg::ACT_SEND),
		(tx_ai == 8'd0) && (tx_cr == 1'b0) && (tx_ri == 16'd0),
		"frame fields set without send action")
	`ASSERT_IMPL(a_assign_clean, out_valid && (action == lapd_pkg::ACT_ASSIGN_REQ),
		tx_msg_type == 3'd0, "assign request carries a frame type")

endmodule
